/* hw/rtl/frt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_pkg
// Shared sizes and request/result types for the fragment reassembly tracker.
// ---------------------------------------------------------------------------
package frt_pkg;

	localparam int FRAG_SHIFT    = 10;
	localparam int FRAGMENT_SIZE = 1 << FRAG_SHIFT;
	localparam int MAX_BLOCKS    = 256;

	localparam int ID_W    = 16;
	localparam int SIZE_W  = 19;
	localparam int BLK_W   = 8;
	localparam int FLEN_W  = 11;
	localparam int POS_W   = FRAG_SHIFT;
	localparam int DATA_W  = 8;
	localparam int ADDR_W  = 18;

	localparam int MAP_W   = $clog2(MAX_BLOCKS);
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int NBLK_W  = SIZE_W - FRAG_SHIFT + 1;
	localparam int CMP_W   = SIZE_W + 1;

	typedef struct packed {
		logic signed [ID_W-1:0] transfer_number;
		logic signed [ID_W-1:0] transfer_ident;
		logic [SIZE_W-1:0]      transfer_bytes;
		logic [BLK_W-1:0]       block_index;
		logic [FLEN_W-1:0]      fragment_length;
		logic [POS_W-1:0]       byte_position;
		logic [DATA_W-1:0]      data_byte;
		logic                   last_of_fragment;
	} frt_item_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic              fragment_done;
		logic              fragment_accepted;
		logic              transfer_complete;
		logic              compressed;
		logic [ADDR_W-1:0] payload_bytes;
	} frt_result_t;

endpackage
`default_nettype wire

/* hw/rtl/frt_in_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_in_if
// Fragment byte channel: valid, ready and one request of fragment payload.
// ---------------------------------------------------------------------------
interface frt_in_if
	import frt_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic signed [ID_W-1:0] transfer_number;
	logic signed [ID_W-1:0] transfer_ident;
	logic [SIZE_W-1:0]      transfer_bytes;
	logic [BLK_W-1:0]       block_index;
	logic [FLEN_W-1:0]      fragment_length;
	logic [POS_W-1:0]       byte_position;
	logic [DATA_W-1:0]      data_byte;
	logic                   last_of_fragment;

	modport source (
		output valid, transfer_number, transfer_ident, transfer_bytes, block_index,
		       fragment_length, byte_position, data_byte, last_of_fragment,
		input  ready
	);
	modport sink (
		input  valid, transfer_number, transfer_ident, transfer_bytes, block_index,
		       fragment_length, byte_position, data_byte, last_of_fragment,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/frt_out_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_out_if
// Result channel: scratch write and fragment status for each byte request.
// ---------------------------------------------------------------------------
interface frt_out_if
	import frt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              write_enable;
	logic [ADDR_W-1:0] write_address;
	logic [DATA_W-1:0] write_data;
	logic              fragment_done;
	logic              fragment_accepted;
	logic              transfer_complete;
	logic              compressed;
	logic [ADDR_W-1:0] payload_bytes;

	modport source (
		output valid, write_enable, write_address, write_data, fragment_done,
		       fragment_accepted, transfer_complete, compressed, payload_bytes,
		input  ready
	);
	modport sink (
		input  valid, write_enable, write_address, write_data, fragment_done,
		       fragment_accepted, transfer_complete, compressed, payload_bytes,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/frt_input_stage.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_input_stage
// Input register that holds one byte request until the tracker consumes it.
// ---------------------------------------------------------------------------
module frt_input_stage
	import frt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	frt_in_if.sink     frag,
	input  wire        advance,
	output logic       valid_s1,
	output frt_item_t  item_s1
);

	assign frag.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frag.ready) begin
			valid_s1 <= frag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frag.valid && frag.ready) begin
			item_s1.transfer_number  <= frag.transfer_number;
			item_s1.transfer_ident   <= frag.transfer_ident;
			item_s1.transfer_bytes   <= frag.transfer_bytes;
			item_s1.block_index      <= frag.block_index;
			item_s1.fragment_length  <= frag.fragment_length;
			item_s1.byte_position    <= frag.byte_position;
			item_s1.data_byte        <= frag.data_byte;
			item_s1.last_of_fragment <= frag.last_of_fragment;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/frt_tracker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_tracker
// Transfer state, received-block bitmap and the per-byte fragment decision.
// ---------------------------------------------------------------------------
module frt_tracker
	import frt_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire signed [ID_W-1:0] cfg_wdata,
	input  wire                   step,
	input  frt_item_t             item,
	output frt_result_t           result
);

	logic signed [ID_W-1:0] exp_id_q;
	logic signed [ID_W-1:0] cur_num_q;
	logic                   started_q;
	logic                   completed_q;
	logic [SIZE_W-1:0]      total_q;
	logic [CNT_W-1:0]       bt_q;
	logic [CNT_W-1:0]       count_q;
	logic [MAX_BLOCKS-1:0]  map_q;
	logic                   acc_q;
	logic                   store_q;
	logic                   comp_q;

	logic signed [ID_W-1:0] exp_id_d;
	logic signed [ID_W-1:0] cur_num_d;
	logic                   started_d;
	logic                   completed_d;
	logic [SIZE_W-1:0]      total_d;
	logic [CNT_W-1:0]       bt_d;
	logic [CNT_W-1:0]       count_d;
	logic [MAX_BLOCKS-1:0]  map_d;
	logic                   acc_d;
	logic                   store_d;
	logic                   comp_d;

	logic                   head;
	logic                   id_ok;
	logic                   in_range;
	logic                   fresh;
	logic [NBLK_W-1:0]      nblk;
	logic [ADDR_W-1:0]      offset;
	logic [CMP_W-1:0]       frag_end;
	logic                   acc_now;
	logic                   store_now;
	logic [SIZE_W-1:0]      pay_full;

	always_comb begin
		exp_id_d    = exp_id_q;
		cur_num_d   = cur_num_q;
		started_d   = started_q;
		completed_d = completed_q;
		total_d     = total_q;
		bt_d        = bt_q;
		count_d     = count_q;
		map_d       = map_q;
		comp_d      = comp_q;
		id_ok       = 1'b0;
		in_range    = 1'b0;
		fresh       = 1'b0;
		head        = (item.byte_position == '0);
		offset      = {item.block_index, {FRAG_SHIFT{1'b0}}};
		frag_end    = CMP_W'(item.fragment_length) + CMP_W'(offset);
		nblk        = NBLK_W'(item.transfer_bytes >> FRAG_SHIFT)
		            + NBLK_W'(|item.transfer_bytes[FRAG_SHIFT-1:0]);
		acc_now     = acc_q;
		store_now   = store_q;

		if (head) begin
			acc_now   = 1'b0;
			store_now = 1'b0;
			if (item.transfer_number != cur_num_q) begin
				cur_num_d   = item.transfer_number;
				started_d   = 1'b0;
				completed_d = 1'b0;
				exp_id_d    = '0;
				bt_d        = '0;
				count_d     = '0;
				map_d       = '0;
			end
			id_ok = (item.transfer_ident == exp_id_d) && !completed_d;
			if (id_ok && !started_d) begin
				started_d = 1'b1;
				total_d   = item.transfer_bytes;
				bt_d      = (nblk > NBLK_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
				                                          : CNT_W'(nblk);
				count_d   = '0;
				map_d     = '0;
			end
			in_range = id_ok && (CNT_W'(item.block_index) < bt_d);
			fresh    = in_range && !map_d[item.block_index[MAP_W-1:0]];
			acc_now  = in_range;
			if (fresh) begin
				store_now = (frag_end <= CMP_W'(total_d));
				count_d   = count_d + CNT_W'(1);
				map_d[item.block_index[MAP_W-1:0]] = 1'b1;
			end
		end

		result.write_enable  = store_now && (FLEN_W'(item.byte_position) < item.fragment_length);
		result.write_address = result.write_enable ?
		                       (offset + ADDR_W'(item.byte_position)) : '0;
		result.write_data    = result.write_enable ? item.data_byte : '0;
		if (result.write_enable && (result.write_address == '0)) begin
			comp_d = (item.data_byte != '0);
		end

		pay_full                 = total_d - SIZE_W'(1);
		result.fragment_done     = item.last_of_fragment;
		result.fragment_accepted = item.last_of_fragment && acc_now;
		result.transfer_complete = item.last_of_fragment && acc_now && (count_d == bt_d);
		result.compressed        = result.transfer_complete && comp_d;
		if (!result.transfer_complete || (total_d == '0)) begin
			result.payload_bytes = '0;
		end else if (pay_full[SIZE_W-1:ADDR_W] != '0) begin
			result.payload_bytes = '1;
		end else begin
			result.payload_bytes = pay_full[ADDR_W-1:0];
		end

		if (result.transfer_complete) begin
			completed_d = 1'b1;
		end
		acc_d   = item.last_of_fragment ? 1'b0 : acc_now;
		store_d = item.last_of_fragment ? 1'b0 : store_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q    <= '0;
			cur_num_q   <= '0;
			started_q   <= 1'b0;
			completed_q <= 1'b0;
			total_q     <= '0;
			bt_q        <= '0;
			count_q     <= '0;
			map_q       <= '0;
			acc_q       <= 1'b0;
			store_q     <= 1'b0;
			comp_q      <= 1'b0;
		end else begin
			if (step) begin
				exp_id_q    <= exp_id_d;
				cur_num_q   <= cur_num_d;
				started_q   <= started_d;
				completed_q <= completed_d;
				total_q     <= total_d;
				bt_q        <= bt_d;
				count_q     <= count_d;
				map_q       <= map_d;
				acc_q       <= acc_d;
				store_q     <= store_d;
				comp_q      <= comp_d;
			end
			if (cfg_we) begin
				exp_id_q <= cfg_wdata;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/frt_output_stage.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_output_stage
// Result register that holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module frt_output_stage
	import frt_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         valid_s1,
	input  frt_result_t result,
	output logic        advance,
	frt_out_if.source   res
);

	logic        valid_q;
	frt_result_t res_q;

	assign advance = valid_s1 && (!valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid             = valid_q;
	assign res.write_enable      = res_q.write_enable;
	assign res.write_address     = res_q.write_address;
	assign res.write_data        = res_q.write_data;
	assign res.fragment_done     = res_q.fragment_done;
	assign res.fragment_accepted = res_q.fragment_accepted;
	assign res.transfer_complete = res_q.transfer_complete;
	assign res.compressed        = res_q.compressed;
	assign res.payload_bytes     = res_q.payload_bytes;

endmodule
`default_nettype wire

/* hw/rtl/fragment_reassembly_tracker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks fragment bytes of one transfer and drives scratch-memory writes.
// ---------------------------------------------------------------------------
// Each fragment byte request passes an input register and a result register,
// so a byte is accepted every cycle unless the result channel stalls, and its
// result is offered from the result register; the rate is one byte per cycle,
// set by the update of the flip-flop block bitmap and counters between those
// registers. The user must write the expected transfer id only while no
// request is in flight; the block itself does not enforce this.
module fragment_reassembly_tracker
	import frt_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_write_enable,
	input  wire signed [ID_W-1:0] cfg_write_data,
	frt_in_if.sink                frag,
	frt_out_if.source             res
);

	logic        valid_s1;
	logic        advance;
	frt_item_t   item_s1;
	frt_result_t result;

	frt_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.frag     (frag),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	frt_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_write_enable),
		.cfg_wdata (cfg_write_data),
		.step      (advance),
		.item      (item_s1),
		.result    (result)
	);

	frt_output_stage u_output (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result   (result),
		.advance  (advance),
		.res      (res)
	);

endmodule
`default_nettype wire

/* hw/rtl/frt_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frt_checker
// Port-level checks on the result channel of the reassembly tracker.
// ---------------------------------------------------------------------------
module frt_checker
	import frt_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              out_valid,
	input wire              out_ready,
	input wire              write_enable,
	input wire [ADDR_W-1:0] write_address,
	input wire [DATA_W-1:0] write_data,
	input wire              fragment_done,
	input wire              fragment_accepted,
	input wire              transfer_complete,
	input wire              compressed,
	input wire [ADDR_W-1:0] payload_bytes
);

	a_quiet_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> (write_address == '0) && (write_data == '0))
		else $error("write fields nonzero without a write");

	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fragment_done |-> !fragment_accepted && !transfer_complete)
		else $error("fragment status reported before the last byte");

	a_complete_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_complete |-> fragment_accepted)
		else $error("transfer completed by a rejected fragment");

	a_summary_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !transfer_complete |-> !compressed && (payload_bytes == '0))
		else $error("completion summary shown without completion");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_address)
		&& $stable(transfer_complete))
		else $error("stalled result changed");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (res.valid),
	.out_ready         (res.ready),
	.write_enable      (res.write_enable),
	.write_address     (res.write_address),
	.write_data        (res.write_data),
	.fragment_done     (res.fragment_done),
	.fragment_accepted (res.fragment_accepted),
	.transfer_complete (res.transfer_complete),
	.compressed        (res.compressed),
	.payload_bytes     (res.payload_bytes)
);
`default_nettype wire

/* test/tb_fragment_reassembly_tracker.sv */
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fragment_reassembly_tracker
// Self-checking bench for the fragment reassembly tracker. Fragment byte
// requests go in through a valid/ready channel with random gaps, and results
// are taken under random backpressure, including one long stall. A behavioral
// tracker predicts each result, which is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_tracker;
	import frt_pkg::*;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	class reassembly_scoreboard;
		logic [ID_W-1:0]       expected_id;
		logic [ID_W-1:0]       transfer_no;
		bit                    started;
		bit                    completed;
		int unsigned           total_size;
		int unsigned           block_total;
		int unsigned           recv_count;
		logic [MAX_BLOCKS-1:0] recv_map;
		bit                    accept_latch;
		bit                    store_latch;
		bit                    header_flag;
		frt_result_t           pending_q[$];
		int                    errors;
		int                    checked;

		function new();
			expected_id  = '0;
			transfer_no  = '0;
			started      = 0;
			completed    = 0;
			total_size   = 0;
			block_total  = 0;
			recv_count   = 0;
			recv_map     = '0;
			accept_latch = 0;
			store_latch  = 0;
			header_flag  = 0;
			errors       = 0;
			checked      = 0;
		endfunction

		function void note_request(frt_item_t it);
			frt_result_t r;
			int unsigned nblk;
			int unsigned pay;
			r = '0;
			if (it.byte_position == 0) begin
				accept_latch = 0;
				store_latch  = 0;
				if (it.transfer_number != transfer_no) begin
					transfer_no = it.transfer_number;
					started     = 0;
					completed   = 0;
					expected_id = '0;
					block_total = 0;
					recv_count  = 0;
					recv_map    = '0;
				end
				if (it.transfer_ident == expected_id && !completed) begin
					if (!started) begin
						nblk        = (it.transfer_bytes + FRAGMENT_SIZE - 1) / FRAGMENT_SIZE;
						started     = 1;
						total_size  = it.transfer_bytes;
						block_total = nblk > MAX_BLOCKS ? MAX_BLOCKS : nblk;
						recv_count  = 0;
						recv_map    = '0;
					end
					if (it.block_index < block_total) begin
						accept_latch = 1;
						if (!recv_map[it.block_index]) begin
							if (it.fragment_length + it.block_index * FRAGMENT_SIZE <= total_size)
								store_latch = 1;
							recv_count++;
							recv_map[it.block_index] = 1'b1;
						end
					end
				end
			end
			if (store_latch && it.byte_position < it.fragment_length) begin
				r.write_enable  = 1'b1;
				r.write_address = ADDR_W'(it.block_index * FRAGMENT_SIZE + it.byte_position);
				r.write_data    = it.data_byte;
				if (r.write_address == 0)
					header_flag = it.data_byte != 0;
			end
			if (it.last_of_fragment) begin
				r.fragment_done     = 1'b1;
				r.fragment_accepted = accept_latch;
				if (accept_latch && recv_count == block_total) begin
					completed           = 1;
					r.transfer_complete = 1'b1;
					r.compressed        = header_flag;
					pay = total_size == 0 ? 0 : total_size - 1;
					r.payload_bytes = pay > 32'h3FFFF ? 18'h3FFFF : ADDR_W'(pay);
				end
				accept_latch = 0;
				store_latch  = 0;
			end
			pending_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(frt_result_t got);
			frt_result_t want;
			checked++;
			if (pending_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			compare_field("write_enable", want.write_enable, got.write_enable);
			compare_field("write_address", want.write_address, got.write_address);
			compare_field("write_data", want.write_data, got.write_data);
			compare_field("fragment_done", want.fragment_done, got.fragment_done);
			compare_field("fragment_accepted", want.fragment_accepted, got.fragment_accepted);
			compare_field("transfer_complete", want.transfer_complete, got.transfer_complete);
			compare_field("compressed", want.compressed, got.compressed);
			compare_field("payload_bytes", want.payload_bytes, got.payload_bytes);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_write_enable;
	logic signed [ID_W-1:0] cfg_write_data;

	frt_in_if  frag_if ();
	frt_out_if res_if ();

	reassembly_scoreboard sb = new();

	int items_sent;
	int send_idle_pct;
	int ready_idle_pct;
	int ready_hold;
	int ready_ticks;
	bit long_hold_done;
	bit no_idle;
	int stuck_cycles;

	fragment_reassembly_tracker dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.frag             (frag_if),
		.res              (res_if)
	);

	always #5 clk = ~clk;

	function automatic int idle_rate();
		case ($urandom_range(3))
			0: return 0;
			1: return 4;
			2: return 15;
			default: return 40;
		endcase
	endfunction

	always @(negedge clk) begin
		ready_ticks++;
		if (ready_ticks % 64 == 0)
			ready_idle_pct = idle_rate();
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			res_if.ready <= 1'b0;
		end else if (!long_hold_done && sb.checked >= 200 && frag_if.valid) begin
			long_hold_done = 1;
			ready_hold = LONG_HOLD - 1;
			res_if.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(99) < ready_idle_pct) begin
			ready_hold = $urandom_range(13, 1) - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result({res_if.write_enable, res_if.write_address, res_if.write_data,
				res_if.fragment_done, res_if.fragment_accepted, res_if.transfer_complete,
				res_if.compressed, res_if.payload_bytes});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frag_if.valid && frag_if.ready) || (res_if.valid && res_if.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("fragment_reassembly_tracker test failed");
				$finish;
			end
		end
	end

	task automatic send_request(input frt_item_t it);
		int gap;
		if (items_sent % 50 == 0)
			send_idle_pct = idle_rate();
		if (!no_idle && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(13, 1);
			@(negedge clk);
			frag_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		frag_if.transfer_number  <= it.transfer_number;
		frag_if.transfer_ident   <= it.transfer_ident;
		frag_if.transfer_bytes   <= it.transfer_bytes;
		frag_if.block_index      <= it.block_index;
		frag_if.fragment_length  <= it.fragment_length;
		frag_if.byte_position    <= it.byte_position;
		frag_if.data_byte        <= it.data_byte;
		frag_if.last_of_fragment <= it.last_of_fragment;
		frag_if.valid            <= 1'b1;
		do @(posedge clk); while (!frag_if.ready);
		sb.note_request(it);
		items_sent++;
	endtask

	task automatic send_fragment(input logic [ID_W-1:0] tnum, input logic [ID_W-1:0] tid,
			input logic [SIZE_W-1:0] tsize, input logic [BLK_W-1:0] blk,
			input logic [FLEN_W-1:0] flen, input int nbytes);
		frt_item_t it;
		for (int i = 0; i < nbytes; i++) begin
			it.transfer_number  = tnum;
			it.transfer_ident   = tid;
			it.transfer_bytes   = tsize;
			it.block_index      = blk;
			it.fragment_length  = flen;
			it.byte_position    = POS_W'(i);
			it.data_byte        = $urandom_range(3) == 0 ? 8'h00 : 8'($urandom);
			it.last_of_fragment = i == nbytes - 1;
			send_request(it);
		end
	endtask

	task automatic send_noise();
		frt_item_t it;
		it.transfer_number  = 16'($urandom);
		it.transfer_ident   = 16'($urandom);
		it.transfer_bytes   = SIZE_W'($urandom_range(262144));
		it.block_index      = 8'($urandom);
		it.fragment_length  = FLEN_W'($urandom_range(1024));
		it.byte_position    = $urandom_range(1) ? '0 : POS_W'($urandom);
		it.data_byte        = 8'($urandom);
		it.last_of_fragment = 1'($urandom);
		send_request(it);
	endtask

	task automatic send_transfer(input bit keep, input bit full);
		logic [ID_W-1:0]   tnum;
		logic [ID_W-1:0]   tid;
		logic [SIZE_W-1:0] tsize;
		logic [FLEN_W-1:0] flen;
		int                nblk;
		int                nbytes;
		int                j;
		int                tmp;
		int                order[$];
		tnum = keep ? sb.transfer_no : 16'($urandom);
		tid = tnum != sb.transfer_no ? '0 : sb.expected_id;
		if (!full && $urandom_range(99) < 12)
			tid = 16'($urandom);
		if (full)
			tsize = SIZE_W'($urandom_range(262144, 261121));
		else if ($urandom_range(99) < 4)
			tsize = '0;
		else if ($urandom_range(99) < 6)
			tsize = SIZE_W'($urandom_range(262144, 4097));
		else
			tsize = SIZE_W'($urandom_range(4096, 1));
		if (tnum == sb.transfer_no && sb.started)
			nblk = sb.block_total;
		else
			nblk = (tsize + FRAGMENT_SIZE - 1) / FRAGMENT_SIZE;
		if (nblk > MAX_BLOCKS)
			nblk = MAX_BLOCKS;
		for (int b = 0; b < nblk; b++)
			order.push_back(b);
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (!full)
			while (order.size() > 6) order.pop_back();
		if (nblk == 0)
			order.push_back($urandom_range(255));
		foreach (order[i]) begin
			nbytes = full ? 1 : $urandom_range(6, 1);
			case ($urandom_range(9))
				7: flen = FLEN_W'($urandom_range(1024));
				8: flen = FLEN_W'(nbytes - 1);
				default: flen = FLEN_W'(nbytes);
			endcase
			send_fragment(tnum, tid, tsize, BLK_W'(order[i]), flen, nbytes);
			if (!full && $urandom_range(99) < 12)
				send_fragment(tnum, tid, tsize, BLK_W'(order[i]), flen, $urandom_range(3, 1));
			if (!full && nblk < MAX_BLOCKS && $urandom_range(99) < 6)
				send_fragment(tnum, tid, tsize, BLK_W'($urandom_range(255, nblk)), 1, 1);
		end
	endtask

	task automatic write_expected_id(input logic [ID_W-1:0] id);
		@(negedge clk);
		frag_if.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_write_enable <= 1'b1;
		cfg_write_data   <= id;
		@(posedge clk);
		sb.expected_id = id;
		@(negedge clk);
		cfg_write_enable <= 1'b0;
	endtask

	initial begin
		logic [ID_W-1:0] phase_ids[5];
		int              phase_end;
		phase_ids = '{16'h7FFF, 16'h0000, 16'($urandom), 16'hFFFF, 16'($urandom)};
		arst_n                   = 1'b0;
		cfg_write_enable         = 1'b0;
		cfg_write_data           = '0;
		frag_if.valid            = 1'b0;
		frag_if.transfer_number  = '0;
		frag_if.transfer_ident   = '0;
		frag_if.transfer_bytes   = '0;
		frag_if.block_index      = '0;
		frag_if.fragment_length  = '0;
		frag_if.byte_position    = '0;
		frag_if.data_byte        = '0;
		frag_if.last_of_fragment = 1'b0;
		res_if.ready             = 1'b0;
		send_idle_pct            = 0;
		ready_idle_pct           = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests: completion, rejections, range edges and saturation.
		write_expected_id(16'h8000);
		send_fragment(16'h0000, 16'h8000, 1, 0, 1, 1);
		send_fragment(16'h0000, 16'h8000, 1, 0, 1, 1);
		send_fragment(16'h7FFF, 16'h0000, 0, 0, 0, 1);
		send_fragment(16'h8000, 16'h1234, 262144, 0, 1, 1);
		send_fragment(16'h8000, 16'h0000, 262144, 255, 1024, 2);
		send_fragment(16'h8000, 16'h0000, 262144, 255, 1024, 1);
		send_fragment(16'h0001, 16'h0000, 1500, 1, 600, 2);
		send_fragment(16'h0001, 16'h0000, 1500, 2, 10, 1);
		send_fragment(16'h0001, 16'h0000, 1500, 0, 3, 5);
		send_noise();
		send_fragment(16'h0002, 16'h0000, 19'h7FFFF, 0, 1024, 1);
		send_fragment(16'h0002, 16'h0000, 19'h7FFFF, 255, 1024, 1);

		for (int p = 0; p < 5; p++) begin
			write_expected_id(phase_ids[p]);
			send_transfer(1, 0);
			if (p == 0)
				send_transfer(0, 1);
			phase_end = items_sent + 290;
			while (items_sent < phase_end) begin
				if (items_sent >= 1600)
					no_idle = 1;
				if ($urandom_range(99) < 25)
					repeat ($urandom_range(3, 1)) send_noise();
				else
					send_transfer($urandom_range(99) < 15, 0);
			end
		end

		@(negedge clk);
		frag_if.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("fragment_reassembly_tracker test passed");
		else
			$display("fragment_reassembly_tracker test failed");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/frt_pkg.sv
hw/rtl/frt_in_if.sv
hw/rtl/frt_out_if.sv
hw/rtl/frt_input_stage.sv
hw/rtl/frt_tracker.sv
hw/rtl/frt_output_stage.sv
hw/rtl/fragment_reassembly_tracker.sv
hw/rtl/frt_checker.sv
test/tb_fragment_reassembly_tracker.sv
